[design/humidity_fan_mode_controller_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the humidity fan mode controller
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_FAN_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define HUMIDITY_FAN_MODE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication
`define HFM_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("hfm check failed");

// Next-cycle implication
`define HFM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("hfm check failed");

`endif

[design/hfm_pkg.sv]
// ----------------------------------------------------------------------------
// hfm_pkg
// Types, codes and constants shared by the fan mode controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hfm_pkg;

	// Mode codes
	localparam logic [1:0] MODE_AUTO    = 2'd0;
	localparam logic [1:0] MODE_ON      = 2'd1;
	localparam logic [1:0] MODE_OFF     = 2'd2;
	localparam logic [1:0] MODE_DELAYED = 2'd3;

	// Press length thresholds (ticks)
	localparam logic [7:0] PRESS_SATURATE = 8'd128;
	localparam logic [7:0] PRESS_MEDIUM   = 8'd64;
	localparam logic [7:0] PRESS_GLITCH   = 8'd2;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_HUMIDITY_LIMIT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_TEMPERATURE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TEMPERATURE_CHK  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RUN_SECONDS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 3'd4;
	localparam int unsigned CFG_DATA_W = 12;

	// Configuration reset values
	localparam logic [6:0]  RST_HUMIDITY_LIMIT   = 7'd55;
	localparam logic [7:0]  RST_MIN_TEMPERATURE  = 8'd22;
	localparam logic        RST_TEMPERATURE_CHK  = 1'b0;
	localparam logic [11:0] RST_MIN_RUN_SECONDS  = 12'd180;
	localparam logic [7:0]  RST_TICKS_PER_SECOND = 8'd62;

	// Interval scaling: minutes = floor(raw * 3 / 50), via reciprocal 3933 / 2^16
	localparam logic [11:0] INTERVAL_MUL   = 12'd3933;
	localparam int unsigned INTERVAL_SHIFT = 16;
	localparam logic [5:0]  INTERVAL_ZERO  = 6'd30;
	localparam int unsigned MINUTES_W      = 6;

	typedef struct packed {
		logic               button_down;
		logic signed [11:0] humidity_tenths;
		logic signed [11:0] temperature_tenths;
		logic [9:0]         interval_raw;
	} in_item_t;

	typedef struct packed {
		logic       fan_on;
		logic       led_on;
		logic [1:0] mode;
		logic       show_settings;
		logic       reset_request;
	} out_item_t;

	typedef struct packed {
		logic [6:0]        humidity_limit;
		logic signed [7:0] minimum_temperature;
		logic              temperature_check;
		logic [11:0]       minimum_run_seconds;
		logic [7:0]        ticks_per_second;
	} cfg_t;

endpackage

`default_nettype wire

[design/hfm_interval.sv]
// ----------------------------------------------------------------------------
// hfm_interval
// Turns the raw potentiometer value into delayed-mode run minutes.
// ----------------------------------------------------------------------------
`default_nettype none

module hfm_interval (
	input  wire logic [9:0]                    interval_raw,
	output logic      [hfm_pkg::MINUTES_W-1:0] minutes
);

	logic [21:0]                   prod;
	logic [hfm_pkg::MINUTES_W-1:0] quot;

	// Multiply by the reciprocal of 50/3 and keep the integer part
	assign prod = {12'd0, interval_raw} * {10'd0, hfm_pkg::INTERVAL_MUL};
	assign quot = prod[hfm_pkg::INTERVAL_SHIFT +: hfm_pkg::MINUTES_W];

	// Zero gives the default interval, otherwise at least one minute
	always_comb begin
		if (interval_raw == 10'd0) begin
			minutes = hfm_pkg::INTERVAL_ZERO;
		end else if (quot == '0) begin
			minutes = hfm_pkg::MINUTES_W'(1);
		end else begin
			minutes = quot;
		end
	end

endmodule

`default_nettype wire

[design/hfm_core.sv]
// ----------------------------------------------------------------------------
// hfm_core
// Controller state and its per-tick update: second divider, button timing,
// mode selection, auto and delayed fan control.
// ----------------------------------------------------------------------------
`default_nettype none

module hfm_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire hfm_pkg::in_item_t                 item,
	input  wire logic [hfm_pkg::MINUTES_W-1:0]     minutes,
	input  wire hfm_pkg::cfg_t                     cfg,
	output hfm_pkg::out_item_t                     result
);

	logic [7:0]  tick_q;
	logic [11:0] auto_run_q;
	logic [11:0] delayed_run_q;
	logic        fan_q;
	logic        may_stop_q;
	logic [1:0]  mode_q;
	logic [7:0]  press_q;
	logic        blink_q;
	logic        led_q;

	logic [7:0]  n_tick;
	logic [11:0] n_auto;
	logic [11:0] n_delayed;
	logic        n_fan;
	logic        n_may_stop;
	logic [1:0]  n_mode;
	logic [7:0]  n_press;
	logic        n_blink;
	logic        n_led;

	logic [7:0]         tps_eff;
	logic               second;
	logic               short_press;
	logic               settings;
	logic               reset_req;
	logic [11:0]        delayed_limit;
	logic [10:0]        hum_limit10;
	logic               hum_high;
	logic signed [12:0] temp_ext;
	logic signed [12:0] min_temp_ext;
	logic signed [12:0] min_temp10;
	logic               cold;

	// Divider of zero behaves as one
	assign tps_eff = (cfg.ticks_per_second == 8'd0) ? 8'd1 : cfg.ticks_per_second;
	assign second  = tick_q >= (tps_eff - 8'd1);

	// Delayed run length in seconds: minutes * 60
	assign delayed_limit = {minutes, 6'd0} - {4'd0, minutes, 2'd0};

	// Thresholds scaled to tenths
	assign hum_limit10  = {1'b0, cfg.humidity_limit, 3'd0} + {3'd0, cfg.humidity_limit, 1'b0};
	assign hum_high     = $signed({item.humidity_tenths[11], item.humidity_tenths})
		> $signed({2'b00, hum_limit10});
	assign temp_ext     = {item.temperature_tenths[11], item.temperature_tenths};
	assign min_temp_ext = {{5{cfg.minimum_temperature[7]}}, cfg.minimum_temperature};
	assign min_temp10   = (min_temp_ext <<< 3) + (min_temp_ext <<< 1);
	assign cold         = cfg.temperature_check && (temp_ext < min_temp10);

	// Work out the state after this tick
	always_comb begin
		n_tick      = tick_q;
		n_auto      = auto_run_q;
		n_delayed   = delayed_run_q;
		n_fan       = fan_q;
		n_may_stop  = may_stop_q;
		n_mode      = mode_q;
		n_press     = press_q;
		n_blink     = blink_q;
		n_led       = led_q;
		short_press = 1'b0;
		settings    = 1'b0;
		reset_req   = 1'b0;

		// One-second event
		if (second) begin
			n_tick = 8'd0;
			if (mode_q == hfm_pkg::MODE_AUTO && fan_q && !may_stop_q) begin
				if (auto_run_q == cfg.minimum_run_seconds) begin
					n_may_stop = 1'b1;
				end
				n_auto = auto_run_q + 12'd1;
			end else begin
				n_auto = 12'd0;
			end
			if (mode_q == hfm_pkg::MODE_DELAYED && fan_q && !may_stop_q) begin
				if (delayed_run_q == delayed_limit) begin
					n_may_stop = 1'b1;
				end
				n_delayed = delayed_run_q + 12'd1;
			end else begin
				n_delayed = 12'd0;
			end
			if (fan_q) begin
				n_blink = ~blink_q;
				n_led   = ~blink_q;
			end else begin
				n_led = 1'b0;
			end
		end else begin
			n_tick = tick_q + 8'd1;
		end

		// Button: count while held, classify on release
		if (item.button_down) begin
			if (press_q < hfm_pkg::PRESS_SATURATE) begin
				n_press = press_q + 8'd1;
			end
		end else begin
			if (press_q > hfm_pkg::PRESS_GLITCH) begin
				if (press_q >= hfm_pkg::PRESS_SATURATE) begin
					reset_req = 1'b1;
				end else if (press_q >= hfm_pkg::PRESS_MEDIUM) begin
					settings = 1'b1;
				end else begin
					short_press = 1'b1;
				end
			end
			n_press = 8'd0;
		end

		// Settings resynchronises the divider
		if (settings) begin
			n_tick = 8'd0;
		end

		// Mode selection on short press
		if (short_press) begin
			n_mode = (mode_q == hfm_pkg::MODE_DELAYED) ? hfm_pkg::MODE_AUTO : mode_q + 2'd1;
			unique case (n_mode)
				hfm_pkg::MODE_ON: begin
					n_fan  = 1'b1;
					n_tick = 8'd0;
				end
				hfm_pkg::MODE_OFF: begin
					n_fan = 1'b0;
				end
				hfm_pkg::MODE_AUTO: begin
					n_may_stop = 1'b1;
					n_tick     = 8'd0;
				end
				default: begin
					n_may_stop = 1'b0;
					n_tick     = 8'd0;
				end
			endcase
		end

		// Auto and delayed control
		if (n_mode == hfm_pkg::MODE_AUTO) begin
			if (hum_high) begin
				if (!cold) begin
					if (!n_fan) begin
						n_fan      = 1'b1;
						n_may_stop = 1'b0;
					end
					n_auto = 12'd0;
				end
			end else if (n_may_stop && n_fan) begin
				n_fan      = 1'b0;
				n_may_stop = 1'b0;
			end
		end else if (n_mode == hfm_pkg::MODE_DELAYED) begin
			if (!n_may_stop) begin
				n_fan = 1'b1;
			end else begin
				if (n_fan) begin
					n_fan      = 1'b0;
					n_may_stop = 1'b0;
				end
				n_mode = hfm_pkg::MODE_AUTO;
			end
		end

		// Long press returns everything to reset
		if (reset_req) begin
			n_tick     = 8'd0;
			n_auto     = 12'd0;
			n_delayed  = 12'd0;
			n_fan      = 1'b0;
			n_may_stop = 1'b0;
			n_mode     = hfm_pkg::MODE_AUTO;
			n_press    = 8'd0;
			n_blink    = 1'b0;
			n_led      = 1'b0;
		end
	end

	// Result as seen after the update
	assign result.fan_on        = n_fan;
	assign result.led_on        = n_led;
	assign result.mode          = n_mode;
	assign result.show_settings = settings;
	assign result.reset_request = reset_req;

	// Advance state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= 8'd0;
			auto_run_q    <= 12'd0;
			delayed_run_q <= 12'd0;
			fan_q         <= 1'b0;
			may_stop_q    <= 1'b0;
			mode_q        <= hfm_pkg::MODE_AUTO;
			press_q       <= 8'd0;
			blink_q       <= 1'b0;
			led_q         <= 1'b0;
		end else if (step) begin
			tick_q        <= n_tick;
			auto_run_q    <= n_auto;
			delayed_run_q <= n_delayed;
			fan_q         <= n_fan;
			may_stop_q    <= n_may_stop;
			mode_q        <= n_mode;
			press_q       <= n_press;
			blink_q       <= n_blink;
			led_q         <= n_led;
		end
	end

endmodule

`default_nettype wire

[design/humidity_fan_mode_controller_unit.sv]
// ----------------------------------------------------------------------------
// humidity_fan_mode_controller_unit
// Pipeline: an accepted item is held in the input register, and its result item is registered in the result register.
// Throughput: one item per cycle while the output is not stalled, set by the single-pass tick update between registers.
// Reset: state clears to auto mode with the fan off; configuration registers take their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_fan_mode_controller_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire hfm_pkg::in_item_t                 in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output hfm_pkg::out_item_t                     out_data,
	input  wire logic                              cfg_we,
	input  wire logic [hfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [hfm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	hfm_pkg::cfg_t                     cfg_q;
	logic                              valid_s1;
	hfm_pkg::in_item_t                 item_s1;
	logic [hfm_pkg::MINUTES_W-1:0]     minutes_s1;
	logic [hfm_pkg::MINUTES_W-1:0]     minutes_in;
	logic                              out_valid_q;
	hfm_pkg::out_item_t                out_q;
	hfm_pkg::out_item_t                result;
	logic                              advance;
	logic                              accept;

	// Move an item on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.humidity_limit      <= hfm_pkg::RST_HUMIDITY_LIMIT;
			cfg_q.minimum_temperature <= hfm_pkg::RST_MIN_TEMPERATURE;
			cfg_q.temperature_check   <= hfm_pkg::RST_TEMPERATURE_CHK;
			cfg_q.minimum_run_seconds <= hfm_pkg::RST_MIN_RUN_SECONDS;
			cfg_q.ticks_per_second    <= hfm_pkg::RST_TICKS_PER_SECOND;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hfm_pkg::CFG_HUMIDITY_LIMIT:   cfg_q.humidity_limit      <= cfg_wdata[6:0];
				hfm_pkg::CFG_MIN_TEMPERATURE:  cfg_q.minimum_temperature <= cfg_wdata[7:0];
				hfm_pkg::CFG_TEMPERATURE_CHK:  cfg_q.temperature_check   <= cfg_wdata[0];
				hfm_pkg::CFG_MIN_RUN_SECONDS:  cfg_q.minimum_run_seconds <= cfg_wdata[11:0];
				hfm_pkg::CFG_TICKS_PER_SECOND: cfg_q.ticks_per_second    <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Scale the interval on the way in
	hfm_interval u_interval (
		.interval_raw (in_data.interval_raw),
		.minutes      (minutes_in)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= in_data;
			minutes_s1 <= minutes_in;
		end
	end

	hfm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.minutes (minutes_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[design/hfm_checker.sv]
// ----------------------------------------------------------------------------
// hfm_checker
// Port-level checks on the fan mode controller's result items.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_fan_mode_controller_unit_assert.svh"

module hfm_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire hfm_pkg::out_item_t out_data
);

	// Held result item stays put
	`HFM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// Off mode never drives the fan, on mode always does
	`HFM_ASSERT_IMPL(a_off_no_fan, clk, arst_n, out_valid && out_data.mode == hfm_pkg::MODE_OFF, !out_data.fan_on)
	`HFM_ASSERT_IMPL(a_on_fan, clk, arst_n, out_valid && out_data.mode == hfm_pkg::MODE_ON, out_data.fan_on)

	// A reset request shows the cleared state and no settings pulse
	`HFM_ASSERT_IMPL(a_reset_clean, clk, arst_n, out_valid && out_data.reset_request, !out_data.fan_on && !out_data.led_on && out_data.mode == hfm_pkg::MODE_AUTO && !out_data.show_settings)

endmodule

bind humidity_fan_mode_controller_unit hfm_checker u_hfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
